// File: hdl/assert_macros.svh
// assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define GSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define GSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// checks what reset leaves behind
`define GSV_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("reset check failed");

`endif

// File: hdl/gsvgl_pkg.sv
// types, constants and tables for the gaussian shell evaluator
package gsvgl_pkg;

  localparam int EXP_BITS = 25;
  localparam logic [24:0] CUTOFF_Q20 = 25'd28973226;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;
  localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GO, ST_WAIT, ST_FAR, ST_AR2, ST_EXP, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_LIM, OP_AR2, OP_EXP,
    OP_VM, OP_GM, OP_TX, OP_TY, OP_TZ, OP_TL
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    op_t  mul_op;
    logic far_upd;
    logic exp_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic far_now;
    logic shell_far;
    logic ar2_skip;
    logic exp_bit;
    logic exp_end;
    logic last;
  } status_t;

  typedef logic [62:0] exp_ent_t;
  typedef exp_ent_t exp_tab_t [EXP_BITS];

  // exp(-2^k) for k = -20..4 in Q.62: taylor series, then squarings
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    logic [63:0] term;
    logic [63:0] tot;
    logic [127:0] sq;
    int sh;
    for (int i = 0; i <= 20; i++) begin
      sh = 20 - i;
      term = ONE_Q62;
      tot = ONE_Q62;
      for (int n = 1; n <= 30; n++) begin
        term = (term >> sh) / 64'(n);
        if (n[0]) begin
          tot = tot - term;
        end else begin
          tot = tot + term;
        end
      end
      tab[i] = tot[62:0];
    end
    for (int i = 21; i < EXP_BITS; i++) begin
      sq = {65'd0, tab[i-1]} * {65'd0, tab[i-1]};
      tab[i] = sq[124:62];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // signed 48-bit accumulate of a magnitude, saturating
  function automatic logic signed [47:0] sat_add(logic signed [47:0] acc,
                                                 logic [48:0] mag, logic neg);
    logic signed [49:0] a50;
    logic signed [49:0] m50;
    logic signed [49:0] r50;
    a50 = {{2{acc[47]}}, acc};
    m50 = {1'b0, mag};
    r50 = neg ? (a50 - m50) : (a50 + m50);
    if (r50 > SUM_MAX) begin
      return SUM_MAX[47:0];
    end else if (r50 < SUM_MIN) begin
      return SUM_MIN[47:0];
    end
    return r50[47:0];
  endfunction

endpackage

// File: hdl/gsvgl_mul.sv
// shared 64x64 multiplier built from one 32x32 product per cycle
module gsvgl_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  import gsvgl_pkg::*;

  localparam logic [1:0] POS_0  = 2'd0;
  localparam logic [1:0] POS_32 = 2'd1;
  localparam logic [1:0] POS_64 = 2'd2;
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LAST = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd6;

  logic [63:0]  a_r, b_r;
  logic [2:0]   phase_r;
  logic [63:0]  pp_r;
  logic [1:0]   pos_r;
  logic         pp_vld_r;
  logic [127:0] prod_r;
  logic [31:0]  a_part, b_part;
  logic [1:0]   pos_nxt;
  logic [127:0] pp_shift;

  always_comb begin
    a_part = (phase_r == 3'd2 || phase_r == 3'd4) ? a_r[63:32] : a_r[31:0];
    b_part = (phase_r == 3'd3 || phase_r == 3'd4) ? b_r[63:32] : b_r[31:0];
    pos_nxt = (phase_r == 3'd1) ? POS_0 : (phase_r == PH_LAST) ? POS_64 : POS_32;
    unique case (pos_r)
      POS_0:   pp_shift = {64'd0, pp_r};
      POS_32:  pp_shift = {32'd0, pp_r, 32'd0};
      POS_64:  pp_shift = {pp_r, 64'd0};
      default: pp_shift = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pp_vld_r <= 1'b0;
    end else if (start) begin
      phase_r  <= 3'd1;
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= (phase_r != PH_IDLE) && (phase_r <= PH_LAST);
      if (phase_r == PH_DONE) begin
        phase_r <= PH_IDLE;
      end else if (phase_r != PH_IDLE) begin
        phase_r <= phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else begin
      pp_r  <= a_part * b_part;
      pos_r <= pos_nxt;
      if (pp_vld_r) begin
        prod_r <= prod_r + pp_shift;
      end
    end
  end

  assign prod = prod_r;
  assign done = (phase_r == PH_DONE);
endmodule

// File: hdl/gsvgl_dp.sv
// datapath: operand capture, operand select, write-back and accumulators
module gsvgl_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gsvgl_pkg::cmd_t          cmd,
  output gsvgl_pkg::status_t       status,
  input  logic signed [31:0]       in_point_x,
  input  logic signed [31:0]       in_point_y,
  input  logic signed [31:0]       in_point_z,
  input  logic signed [31:0]       in_nucleus_x,
  input  logic signed [31:0]       in_nucleus_y,
  input  logic signed [31:0]       in_nucleus_z,
  input  logic [31:0]              in_nucleus_reach,
  input  logic [31:0]              in_exponent,
  input  logic signed [31:0]       in_coefficient,
  input  logic                     in_last_primitive,
  output logic signed [47:0]       out_value,
  output logic signed [47:0]       out_grad_x,
  output logic signed [47:0]       out_grad_y,
  output logic signed [47:0]       out_grad_z,
  output logic signed [47:0]       out_laplacian,
  output logic                     out_beyond_range
);
  import gsvgl_pkg::*;

  function automatic logic [31:0] mag33(logic [32:0] v);
    return v[32] ? 32'(33'd0 - v) : v[31:0];
  endfunction

  function automatic logic [48:0] cap_term(logic [108:0] v);
    return (v > 109'(TERM_CAP)) ? TERM_CAP : v[48:0];
  endfunction

  logic [31:0] ax_r, ay_r, az_r, reach_r, expo_r, cmag_r;
  logic        sx_r, sy_r, sz_r, cneg_r, last_r;
  logic [45:0] r2_r;
  logic [56:0] lim_r;
  logic [24:0] ar2_r;
  logic        ar2_skip_r;
  logic [4:0]  exp_idx_r;
  logic [62:0] acc_r;
  logic [39:0] vm_r;
  logic [48:0] gm_r;
  logic        gneg_r;
  logic        shell_far_r;
  logic signed [47:0] sum_v_r, sum_gx_r, sum_gy_r, sum_gz_r, sum_l_r;

  logic [32:0]  dx, dy, dz, cext;
  logic [63:0]  op_a, op_b;
  logic [127:0] prod;
  logic         mul_done;
  logic         far_now;
  logic [63:0]  e_rnd;
  logic [32:0]  e_val;
  logic [26:0]  three_q20, two_ar2, kmag;
  logic         kneg;
  logic [64:0]  v_rnd;
  logic [39:0]  vm_nxt;
  logic [48:0]  term;

  assign dx   = {in_point_x[31], in_point_x} - {in_nucleus_x[31], in_nucleus_x};
  assign dy   = {in_point_y[31], in_point_y} - {in_nucleus_y[31], in_nucleus_y};
  assign dz   = {in_point_z[31], in_point_z} - {in_nucleus_z[31], in_nucleus_z};
  assign cext = {in_coefficient[31], in_coefficient};

  assign far_now = (r2_r[45:37] != 9'd0) || ({r2_r, 20'd0} > {9'd0, lim_r});

  // exp(-ar2) back to Q.32 with rounding
  assign e_rnd = {1'b0, acc_r} + 64'(1 << 29);
  assign e_val = e_rnd[62:30];

  // laplacian factor 3 - 2*ar2 in Q.20 as sign and magnitude
  assign three_q20 = 27'(3 << 20);
  assign two_ar2   = {1'b0, ar2_r, 1'b0};
  assign kneg      = two_ar2 > three_q20;
  assign kmag      = kneg ? (two_ar2 - three_q20) : (three_q20 - two_ar2);

  assign v_rnd  = {1'b0, prod[63:0]} + 65'(1 << 23);
  assign vm_nxt = v_rnd[63:24];
  assign term   = cap_term({1'b0, prod[127:20]});

  always_comb begin
    unique case (cmd.mul_op)
      OP_SQX:  begin op_a = {32'd0, ax_r};   op_b = {32'd0, ax_r};    end
      OP_SQY:  begin op_a = {32'd0, ay_r};   op_b = {32'd0, ay_r};    end
      OP_SQZ:  begin op_a = {32'd0, az_r};   op_b = {32'd0, az_r};    end
      OP_LIM:  begin op_a = 64'(CUTOFF_Q20); op_b = {32'd0, reach_r}; end
      OP_AR2:  begin op_a = {32'd0, expo_r}; op_b = {18'd0, r2_r};    end
      OP_EXP:  begin op_a = {1'b0, acc_r};   op_b = {1'b0, EXP_TAB[exp_idx_r]}; end
      OP_VM:   begin op_a = {32'd0, cmag_r}; op_b = {31'd0, e_val};   end
      OP_GM:   begin op_a = {24'd0, vm_r};   op_b = {32'd0, expo_r};  end
      OP_TX:   begin op_a = {15'd0, gm_r};   op_b = {32'd0, ax_r};    end
      OP_TY:   begin op_a = {15'd0, gm_r};   op_b = {32'd0, ay_r};    end
      OP_TZ:   begin op_a = {15'd0, gm_r};   op_b = {32'd0, az_r};    end
      OP_TL:   begin op_a = {15'd0, gm_r};   op_b = {37'd0, kmag};    end
      default: begin op_a = '0;              op_b = '0;               end
    endcase
  end

  gsvgl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (op_a),
    .b     (op_b),
    .prod  (prod),
    .done  (mul_done)
  );

  // shell state: sums and far flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r     <= '0;
      sum_gx_r    <= '0;
      sum_gy_r    <= '0;
      sum_gz_r    <= '0;
      sum_l_r     <= '0;
      shell_far_r <= 1'b0;
    end else if (cmd.emit) begin
      sum_v_r     <= '0;
      sum_gx_r    <= '0;
      sum_gy_r    <= '0;
      sum_gz_r    <= '0;
      sum_l_r     <= '0;
      shell_far_r <= 1'b0;
    end else begin
      if (cmd.far_upd && far_now) begin
        shell_far_r <= 1'b1;
      end
      if (mul_done) begin
        unique case (cmd.mul_op)
          OP_VM:   sum_v_r  <= sat_add(sum_v_r, {9'd0, vm_nxt}, cneg_r);
          OP_TX:   sum_gx_r <= sat_add(sum_gx_r, term, gneg_r ^ sx_r);
          OP_TY:   sum_gy_r <= sat_add(sum_gy_r, term, gneg_r ^ sy_r);
          OP_TZ:   sum_gz_r <= sat_add(sum_gz_r, term, gneg_r ^ sz_r);
          OP_TL:   sum_l_r  <= sat_add(sum_l_r, term, gneg_r ^ kneg);
          default: ;
        endcase
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= mag33(dx);
      ay_r    <= mag33(dy);
      az_r    <= mag33(dz);
      sx_r    <= dx[32];
      sy_r    <= dy[32];
      sz_r    <= dz[32];
      reach_r <= in_nucleus_reach;
      expo_r  <= in_exponent;
      cmag_r  <= mag33(cext);
      cneg_r  <= in_coefficient[31];
      last_r  <= in_last_primitive;
    end
    if (cmd.exp_next) begin
      exp_idx_r <= exp_idx_r + 5'd1;
    end
    if (mul_done) begin
      unique case (cmd.mul_op)
        OP_SQX: r2_r <= 46'(prod[63:20]);
        OP_SQY: r2_r <= r2_r + 46'(prod[63:20]);
        OP_SQZ: r2_r <= r2_r + 46'(prod[63:20]);
        OP_LIM: lim_r <= prod[56:0];
        OP_AR2: begin
          ar2_r      <= prod[44:20];
          ar2_skip_r <= prod[127:20] > 108'(CUTOFF_Q20);
          exp_idx_r  <= '0;
          acc_r      <= ONE_Q62[62:0];
        end
        OP_EXP: begin
          acc_r     <= prod[124:62];
          exp_idx_r <= exp_idx_r + 5'd1;
        end
        OP_VM: begin
          vm_r   <= vm_nxt;
          gneg_r <= !cneg_r && (vm_nxt != 40'd0);
        end
        OP_GM:   gm_r <= cap_term(prod[127:19]);
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_value        <= shell_far_r ? '0 : sum_v_r;
      out_grad_x       <= shell_far_r ? '0 : sum_gx_r;
      out_grad_y       <= shell_far_r ? '0 : sum_gy_r;
      out_grad_z       <= shell_far_r ? '0 : sum_gz_r;
      out_laplacian    <= shell_far_r ? '0 : sum_l_r;
      out_beyond_range <= shell_far_r;
    end
  end

  always_comb begin
    status.mul_done  = mul_done;
    status.far_now   = far_now;
    status.shell_far = shell_far_r;
    status.ar2_skip  = ar2_skip_r;
    status.exp_end   = (exp_idx_r == 5'(EXP_BITS));
    status.exp_bit   = (exp_idx_r < 5'(EXP_BITS)) ? ar2_r[exp_idx_r] : 1'b0;
    status.last      = last_r;
  end
endmodule

// File: hdl/gsvgl_ctrl.sv
// controller: sequences one primitive through the shared multiplier
module gsvgl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  gsvgl_pkg::status_t status,
  output gsvgl_pkg::cmd_t    cmd
);
  import gsvgl_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = OP_SQX;
          state_nxt = ST_GO;
        end
      end
      ST_GO: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (status.mul_done) begin
          state_nxt = ST_GO;
          unique case (op_r)
            OP_SQX:  op_nxt = OP_SQY;
            OP_SQY:  op_nxt = OP_SQZ;
            OP_SQZ:  op_nxt = OP_LIM;
            OP_LIM:  state_nxt = ST_FAR;
            OP_AR2:  state_nxt = ST_AR2;
            OP_EXP:  state_nxt = ST_EXP;
            OP_VM:   op_nxt = OP_GM;
            OP_GM:   op_nxt = OP_TX;
            OP_TX:   op_nxt = OP_TY;
            OP_TY:   op_nxt = OP_TZ;
            OP_TZ:   op_nxt = OP_TL;
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_FAR: begin
        if (status.shell_far || status.far_now) begin
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = OP_AR2;
          state_nxt = ST_GO;
        end
      end
      ST_AR2: state_nxt = status.ar2_skip ? ST_FIN : ST_EXP;
      ST_EXP: begin
        priority if (status.exp_end) begin
          op_nxt    = OP_VM;
          state_nxt = ST_GO;
        end else if (status.exp_bit) begin
          op_nxt    = OP_EXP;
          state_nxt = ST_GO;
        end
      end
      ST_FIN: begin
        if (!status.last || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = op_r;
    unique case (state_r)
      ST_IDLE: cmd.load      = in_valid;
      ST_GO:   cmd.mul_start = 1'b1;
      ST_FAR:  cmd.far_upd   = 1'b1;
      ST_EXP:  cmd.exp_next  = !status.exp_end && !status.exp_bit;
      ST_FIN:  cmd.emit      = status.last && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SQX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: hdl/gaussian_shell_value_gradient_laplacian_core.sv
// top level of the contracted gaussian shell evaluator
//
// Takes the primitives of one shell, one transaction each, and returns one
// result transaction (value, three gradient terms, laplacian term, all Q16.32
// saturating) on the primitive marked last; a shell that fails the nucleus
// range cutoff returns zeros with beyond_range set. Primitives are processed
// one at a time: every product goes through a single 32x32 multiplier that
// builds a 64x64 product from four partial products. A far shell ends the
// primitive after the range test and the exponent cutoff ends it after a*r2;
// otherwise the exponential takes one table product per set bit of the
// 25-bit scaled distance a*r2, which never exceeds the cutoff, so at most 24
// bits are set. A finished result sits in an output register, so the next
// primitive is taken while it waits.
module gaussian_shell_value_gradient_laplacian_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_nucleus_x,
  input  logic signed [31:0] in_nucleus_y,
  input  logic signed [31:0] in_nucleus_z,
  input  logic [31:0]        in_nucleus_reach,
  input  logic [31:0]        in_exponent,
  input  logic signed [31:0] in_coefficient,
  input  logic               in_last_primitive,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_value,
  output logic signed [47:0] out_grad_x,
  output logic signed [47:0] out_grad_y,
  output logic signed [47:0] out_grad_z,
  output logic signed [47:0] out_laplacian,
  output logic               out_beyond_range
);
  import gsvgl_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: one primitive at a time, owns the handshakes
  gsvgl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, shell accumulators and result register
  gsvgl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_nucleus_x      (in_nucleus_x),
    .in_nucleus_y      (in_nucleus_y),
    .in_nucleus_z      (in_nucleus_z),
    .in_nucleus_reach  (in_nucleus_reach),
    .in_exponent       (in_exponent),
    .in_coefficient    (in_coefficient),
    .in_last_primitive (in_last_primitive),
    .out_value         (out_value),
    .out_grad_x        (out_grad_x),
    .out_grad_y        (out_grad_y),
    .out_grad_z        (out_grad_z),
    .out_laplacian     (out_laplacian),
    .out_beyond_range  (out_beyond_range)
  );
endmodule

// File: hdl/gsvgl_checker.sv
// port-level checks for the shell evaluator, bound to the top level
module gsvgl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_point_x,
  input logic signed [31:0] in_point_y,
  input logic signed [31:0] in_point_z,
  input logic signed [31:0] in_nucleus_x,
  input logic signed [31:0] in_nucleus_y,
  input logic signed [31:0] in_nucleus_z,
  input logic [31:0]        in_nucleus_reach,
  input logic [31:0]        in_exponent,
  input logic signed [31:0] in_coefficient,
  input logic               in_last_primitive,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_value,
  input logic signed [47:0] out_grad_x,
  input logic signed [47:0] out_grad_y,
  input logic signed [47:0] out_grad_z,
  input logic signed [47:0] out_laplacian,
  input logic               out_beyond_range
);
`include "assert_macros.svh"

  // a far shell reports all sums as zero
  `GSV_ASSERT_IMP(a_far_zero, clk, rst_n, out_valid && out_beyond_range, out_value == 48'sd0 && out_grad_x == 48'sd0 && out_grad_y == 48'sd0 && out_grad_z == 48'sd0 && out_laplacian == 48'sd0)

  // one primitive at a time: an accepted transaction blocks the next cycle
  `GSV_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // stalled result holds valid, value, laplacian and range flag
  `GSV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_laplacian) && $stable(out_beyond_range))

  // reset leaves no pending result
  `GSV_ASSERT_RST(a_rst_empty, clk, rst_n, !out_valid)
endmodule

bind gaussian_shell_value_gradient_laplacian_core gsvgl_checker u_chk (.*);
